[hw/rtl/cbt_pkg.sv]
// Shared types, constants and request codes for the channel binding table.
package cbt_pkg;

  localparam int unsigned EntriesDefault = 16;

  localparam logic [15:0] ChanMin = 16'h4000;
  localparam logic [15:0] ChanMax = 16'h7fff;
  localparam logic [15:0] LifetimeReset = 16'd600;

  // Configuration register indexes
  localparam logic [7:0] RegRelayFamily = 8'd0;
  localparam logic [7:0] RegLifetime    = 8'd1;

  // Operation codes
  localparam logic [1:0] OpBind     = 2'd0;
  localparam logic [1:0] OpFindNum  = 2'd1;
  localparam logic [1:0] OpFindPeer = 2'd2;

  // Result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadAttr  = 3'd1;
  localparam logic [2:0] StFamily   = 3'd2;
  localparam logic [2:0] StBound    = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;

  // Request classes decided by the front end
  typedef enum logic [2:0] {
    KindBadAttr,
    KindFamily,
    KindBind,
    KindFindNum,
    KindFindPeer
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] channel;
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [31:0] now;
    logic [31:0] expiry;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        created;
    logic [15:0] channel;
    logic        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
    logic [4:0]  count;
  } res_t;

endpackage

[hw/rtl/channel_binding_table_unit.sv]
// Top level of the channel binding table: front end, request queue, table, result queue.
//
//  channel  direction  handshake            payload
//  request  in         push / full          operation .. now_seconds
//  result   out        pop / empty          status .. bound_count
//  config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request passes the table sequencer in order: take, number match, peer match,
// execute. No new request is taken until the current one is through, and execute
// waits while the result queue is full. Two-entry queues sit before and after the
// table, so up to two requests and two results wait while either side stalls.
// Reset clears all bindings at once; the configuration port is always ready.
module channel_binding_table_unit #(
  parameter int unsigned ENTRIES = cbt_pkg::EntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic        has_channel_number_i,
  input  logic [15:0] channel_number_i,
  input  logic        has_peer_i,
  input  logic        peer_family_i,
  input  logic [63:0] peer_addr_hi_i,
  input  logic [63:0] peer_addr_lo_i,
  input  logic [15:0] peer_port_i,
  input  logic [31:0] now_seconds_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic        created_o,
  output logic [15:0] found_channel_o,
  output logic        found_family_o,
  output logic [63:0] found_addr_hi_o,
  output logic [63:0] found_addr_lo_o,
  output logic [15:0] found_port_o,
  output logic [4:0]  bound_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic          relay_family_q;
  logic [15:0]   lifetime_q;
  cbt_pkg::req_t front_req, q_req;
  cbt_pkg::res_t back_res, out_res;
  logic          req_empty, req_pop, res_full, res_push;

  assign cfg_ready_o = 1'b1;

  // Update configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_family_q <= 1'b0;
      lifetime_q     <= cbt_pkg::LifetimeReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cbt_pkg::RegRelayFamily: relay_family_q <= cfg_data_i[0];
        cbt_pkg::RegLifetime:    lifetime_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbt_front u_front (
    .relay_family_i       (relay_family_q),
    .lifetime_i           (lifetime_q),
    .operation_i          (operation_i),
    .has_channel_number_i (has_channel_number_i),
    .channel_number_i     (channel_number_i),
    .has_peer_i           (has_peer_i),
    .peer_family_i        (peer_family_i),
    .peer_addr_hi_i       (peer_addr_hi_i),
    .peer_addr_lo_i       (peer_addr_lo_i),
    .peer_port_i          (peer_port_i),
    .now_seconds_i        (now_seconds_i),
    .req_o                (front_req)
  );

  cbt_fifo #(.WIDTH($bits(cbt_pkg::req_t)), .DEPTH(2)) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_req),
    .full_o  (full),
    .pop_i   (req_pop),
    .rdata_o (q_req),
    .empty_o (req_empty)
  );

  cbt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_empty_i (req_empty),
    .req_i       (q_req),
    .req_pop_o   (req_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  cbt_fifo #(.WIDTH($bits(cbt_pkg::res_t)), .DEPTH(2)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign status_o        = out_res.status;
  assign created_o       = out_res.created;
  assign found_channel_o = out_res.channel;
  assign found_family_o  = out_res.family;
  assign found_addr_hi_o = out_res.addr_hi;
  assign found_addr_lo_o = out_res.addr_lo;
  assign found_port_o    = out_res.port;
  assign bound_count_o   = out_res.count;

endmodule

[hw/rtl/cbt_fifo.sv]
// Small register queue used between the stages and on the result side.
module cbt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/cbt_front.sv]
// Front end: checks attributes, normalizes the peer and computes the new expiry.
module cbt_front (
  input  logic              relay_family_i,
  input  logic [15:0]       lifetime_i,
  input  logic [1:0]        operation_i,
  input  logic              has_channel_number_i,
  input  logic [15:0]       channel_number_i,
  input  logic              has_peer_i,
  input  logic              peer_family_i,
  input  logic [63:0]       peer_addr_hi_i,
  input  logic [63:0]       peer_addr_lo_i,
  input  logic [15:0]       peer_port_i,
  input  logic [31:0]       now_seconds_i,
  output cbt_pkg::req_t     req_o
);
  logic [32:0] exp_sum;
  logic        attr_ok;

  // Saturating expiry
  assign exp_sum = {1'b0, now_seconds_i} + {17'd0, lifetime_i};
  assign attr_ok = has_channel_number_i && has_peer_i &&
                   (channel_number_i >= cbt_pkg::ChanMin) &&
                   (channel_number_i <= cbt_pkg::ChanMax);

  always_comb begin
    req_o.channel = channel_number_i;
    req_o.family  = peer_family_i;
    req_o.addr_hi = peer_family_i ? peer_addr_hi_i : 64'd0;
    req_o.addr_lo = peer_family_i ? peer_addr_lo_i : {32'd0, peer_addr_lo_i[31:0]};
    req_o.port    = peer_port_i;
    req_o.now     = now_seconds_i;
    req_o.expiry  = exp_sum[32] ? 32'hffff_ffff : exp_sum[31:0];
    // Classify the request
    case (operation_i)
      cbt_pkg::OpBind: begin
        if (!attr_ok) begin
          req_o.kind = cbt_pkg::KindBadAttr;
        end else if (peer_family_i != relay_family_i) begin
          req_o.kind = cbt_pkg::KindFamily;
        end else begin
          req_o.kind = cbt_pkg::KindBind;
        end
      end
      cbt_pkg::OpFindNum:  req_o.kind = cbt_pkg::KindFindNum;
      cbt_pkg::OpFindPeer: req_o.kind = cbt_pkg::KindFindPeer;
      default:             req_o.kind = cbt_pkg::KindBadAttr;
    endcase
  end

endmodule

[hw/rtl/cbt_back.sv]
// Back end: binding table, match by number and by peer, expiry drop and update.
module cbt_back #(
  parameter int unsigned ENTRIES = cbt_pkg::EntriesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_empty_i,
  input  cbt_pkg::req_t req_i,
  output logic          req_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output cbt_pkg::res_t res_o
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SNum  = 2'd1;
  localparam logic [1:0] SPeer = 2'd2;
  localparam logic [1:0] SExec = 2'd3;

  logic [1:0]         state_q;
  cbt_pkg::req_t      item_q;
  logic [ENTRIES-1:0] valid_q;
  logic [15:0]        chan_q   [ENTRIES];
  logic               fam_q    [ENTRIES];
  logic [63:0]        hi_q     [ENTRIES];
  logic [63:0]        lo_q     [ENTRIES];
  logic [15:0]        port_q   [ENTRIES];
  logic [31:0]        expiry_q [ENTRIES];
  logic [CntW-1:0]    cnt_q;
  logic               a_found_q, b_found_q;
  logic [IdxW-1:0]    a_idx_q, b_idx_q;

  logic [ENTRIES-1:0] num_match, peer_match;
  logic               num_hit, peer_hit, free_hit;
  logic [IdxW-1:0]    num_idx, peer_idx, free_idx;

  // Match vectors against the live entries
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      num_match[i]  = valid_q[i] && (chan_q[i] == item_q.channel);
      peer_match[i] = valid_q[i] && (fam_q[i] == item_q.family) &&
                      (hi_q[i] == item_q.addr_hi) && (lo_q[i] == item_q.addr_lo) &&
                      (port_q[i] == item_q.port);
    end
  end

  // Lowest index wins
  always_comb begin
    num_hit  = 1'b0;
    peer_hit = 1'b0;
    free_hit = 1'b0;
    num_idx  = '0;
    peer_idx = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (num_match[i]) begin
        num_hit = 1'b1;
        num_idx = IdxW'(i);
      end
      if (peer_match[i]) begin
        peer_hit = 1'b1;
        peer_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Decide the outcome in the execute step
  logic            is_bind, same, do_refresh, do_create, hit;
  logic [IdxW-1:0] hit_idx;
  logic [2:0]      status;
  logic [CntW-1:0] cnt_after;
  logic [31:0]     cnt_wide;

  assign is_bind    = (item_q.kind == cbt_pkg::KindBind);
  assign same       = (a_found_q == b_found_q) && (!a_found_q || (a_idx_q == b_idx_q));
  assign do_refresh = is_bind && same && a_found_q;
  assign do_create  = is_bind && same && !a_found_q && free_hit;

  always_comb begin
    status  = cbt_pkg::StOk;
    hit     = 1'b0;
    hit_idx = a_idx_q;
    case (item_q.kind)
      cbt_pkg::KindBadAttr: status = cbt_pkg::StBadAttr;
      cbt_pkg::KindFamily:  status = cbt_pkg::StFamily;
      cbt_pkg::KindBind: begin
        if (!same) begin
          status = cbt_pkg::StBound;
        end else if (a_found_q) begin
          hit = 1'b1;
        end else if (!free_hit) begin
          status = cbt_pkg::StFull;
        end
      end
      cbt_pkg::KindFindNum: begin
        hit = a_found_q;
        if (!a_found_q) status = cbt_pkg::StNotFound;
      end
      cbt_pkg::KindFindPeer: begin
        hit     = b_found_q;
        hit_idx = b_idx_q;
        if (!b_found_q) status = cbt_pkg::StNotFound;
      end
      default: status = cbt_pkg::StBadAttr;
    endcase
  end

  assign cnt_after = do_create ? cnt_q + 1'b1 : cnt_q;
  assign cnt_wide  = 32'(cnt_after);

  always_comb begin
    res_o.status  = status;
    res_o.created = do_create;
    res_o.count   = cnt_wide[4:0];
    if (do_create) begin
      res_o.channel = item_q.channel;
      res_o.family  = item_q.family;
      res_o.addr_hi = item_q.addr_hi;
      res_o.addr_lo = item_q.addr_lo;
      res_o.port    = item_q.port;
    end else if (hit) begin
      res_o.channel = chan_q[hit_idx];
      res_o.family  = fam_q[hit_idx];
      res_o.addr_hi = hi_q[hit_idx];
      res_o.addr_lo = lo_q[hit_idx];
      res_o.port    = port_q[hit_idx];
    end else begin
      res_o.channel = '0;
      res_o.family  = 1'b0;
      res_o.addr_hi = '0;
      res_o.addr_lo = '0;
      res_o.port    = '0;
    end
  end

  assign req_pop_o  = (state_q == SIdle) && !req_empty_i;
  assign res_push_o = (state_q == SExec) && !res_full_i;

  // Sequence one request: take, number match, peer match, execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      valid_q   <= '0;
      cnt_q     <= '0;
      a_found_q <= 1'b0;
      b_found_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (!req_empty_i) begin
            state_q   <= SNum;
            a_found_q <= 1'b0;
            b_found_q <= 1'b0;
          end
        end
        SNum: begin
          state_q <= SPeer;
          if ((item_q.kind == cbt_pkg::KindBind || item_q.kind == cbt_pkg::KindFindNum)
              && num_hit) begin
            // Drop an expired entry
            if (expiry_q[num_idx] < item_q.now) begin
              valid_q[num_idx] <= 1'b0;
              cnt_q            <= cnt_q - 1'b1;
            end else begin
              a_found_q <= 1'b1;
            end
          end
        end
        SPeer: begin
          state_q <= SExec;
          if ((item_q.kind == cbt_pkg::KindBind || item_q.kind == cbt_pkg::KindFindPeer)
              && peer_hit) begin
            if (expiry_q[peer_idx] < item_q.now) begin
              valid_q[peer_idx] <= 1'b0;
              cnt_q             <= cnt_q - 1'b1;
            end else begin
              b_found_q <= 1'b1;
            end
          end
        end
        SExec: begin
          if (!res_full_i) begin
            state_q <= SIdle;
            if (do_create) begin
              valid_q[free_idx] <= 1'b1;
              cnt_q             <= cnt_after;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Hold request, match indexes and entry payload
  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      item_q <= req_i;
    end
    if (state_q == SNum) begin
      a_idx_q <= num_idx;
    end
    if (state_q == SPeer) begin
      b_idx_q <= peer_idx;
    end
    if (res_push_o && do_refresh) begin
      expiry_q[a_idx_q] <= item_q.expiry;
    end
    if (res_push_o && do_create) begin
      chan_q[free_idx]   <= item_q.channel;
      fam_q[free_idx]    <= item_q.family;
      hi_q[free_idx]     <= item_q.addr_hi;
      lo_q[free_idx]     <= item_q.addr_lo;
      port_q[free_idx]   <= item_q.port;
      expiry_q[free_idx] <= item_q.expiry;
    end
  end

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) == $countones(valid_q))
    else $error("live count differs from valid entries");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result written into a full queue");

  a_take_starts_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop_o |=> state_q == SNum)
    else $error("request taken without match step");

  a_create_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && do_create) |-> !valid_q[free_idx])
    else $error("create over a live entry");

endmodule

[sim/testbench.sv]
// Testbench for the channel binding table: directed table, random traffic, self-predicting checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 16;
  localparam int PoolSize = 24;
  localparam int ItemsPerPhase = 360;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic        has_num;
    logic [15:0] num;
    logic        has_peer;
    logic        fam;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
    logic [31:0] now;
    bit          fixed;
    logic [2:0]  fixed_status;
    logic [4:0]  fixed_count;
  } chan_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation_i = '0;
  logic has_channel_number_i = 1'b0;
  logic [15:0] channel_number_i = '0;
  logic has_peer_i = 1'b0;
  logic peer_family_i = 1'b0;
  logic [63:0] peer_addr_hi_i = '0;
  logic [63:0] peer_addr_lo_i = '0;
  logic [15:0] peer_port_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] status_o;
  logic created_o;
  logic [15:0] found_channel_o;
  logic found_family_o;
  logic [63:0] found_addr_hi_o;
  logic [63:0] found_addr_lo_o;
  logic [15:0] found_port_o;
  logic [4:0] bound_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  channel_binding_table_unit dut (.*);

  // Predictor copy of the table and registers
  logic        tbl_valid [Slots];
  logic [15:0] tbl_chan [Slots];
  logic        tbl_fam [Slots];
  logic [63:0] tbl_hi [Slots];
  logic [63:0] tbl_lo [Slots];
  logic [15:0] tbl_port [Slots];
  logic [31:0] tbl_expiry [Slots];
  logic [4:0]  live_bindings;
  logic        relay_fam;
  logic [15:0] lifetime;

  cbt_pkg::res_t pending_results [$];
  int mismatches = 0;
  int cycles = 0;
  bit rx_hold = 1'b0;
  bit quiet_window = 1'b0;

  // Random traffic pools
  logic [15:0] pool_chan [PoolSize];
  logic [63:0] pool_hi [PoolSize];
  logic [63:0] pool_lo [PoolSize];
  logic [15:0] pool_port [PoolSize];
  logic [31:0] clock_now;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL channel_binding_table_unit");
      $finish;
    end
  end

  // Drop a binding whose expiry is behind now
  function automatic void age_out(int i, logic [31:0] now);
    if (tbl_expiry[i] < now) begin
      tbl_valid[i] = 1'b0;
      if (live_bindings > 0) live_bindings = live_bindings - 1;
    end
  endfunction

  function automatic int lookup_channel(logic [15:0] n, logic [31:0] now);
    for (int i = 0; i < Slots; i++) begin
      if (tbl_valid[i] && tbl_chan[i] == n) begin
        age_out(i, now);
        return tbl_valid[i] ? i : -1;
      end
    end
    return -1;
  endfunction

  function automatic int lookup_peer(logic f, logic [63:0] hi, logic [63:0] lo,
                                     logic [15:0] port, logic [31:0] now);
    for (int i = 0; i < Slots; i++) begin
      if (tbl_valid[i] && tbl_fam[i] == f && tbl_hi[i] == hi && tbl_lo[i] == lo &&
          tbl_port[i] == port) begin
        age_out(i, now);
        return tbl_valid[i] ? i : -1;
      end
    end
    return -1;
  endfunction

  function automatic logic [31:0] expiry_after(logic [31:0] now);
    logic [32:0] sum;
    sum = {1'b0, now} + {17'd0, lifetime};
    return sum[32] ? 32'hffff_ffff : sum[31:0];
  endfunction

  // Apply one request to the predictor table and return the binding result
  function automatic cbt_pkg::res_t apply_request(chan_req_t r);
    cbt_pkg::res_t res;
    logic [63:0] hi;
    logic [63:0] lo;
    int hit;
    int a;
    int b;
    int k;
    hi = r.fam ? r.hi : 64'd0;
    lo = r.fam ? r.lo : {32'd0, r.lo[31:0]};
    hit = -1;
    res = '0;
    res.status = cbt_pkg::StOk;
    case (r.op)
      cbt_pkg::OpBind: begin
        if (!r.has_num || !r.has_peer || r.num < cbt_pkg::ChanMin ||
            r.num > cbt_pkg::ChanMax) begin
          res.status = cbt_pkg::StBadAttr;
        end else if (r.fam != relay_fam) begin
          res.status = cbt_pkg::StFamily;
        end else begin
          a = lookup_channel(r.num, r.now);
          b = lookup_peer(r.fam, hi, lo, r.port, r.now);
          if (a != b) begin
            res.status = cbt_pkg::StBound;
          end else if (a >= 0) begin
            tbl_expiry[a] = expiry_after(r.now);
            hit = a;
          end else begin
            k = 0;
            while (k < Slots && tbl_valid[k]) k++;
            if (k >= Slots) begin
              res.status = cbt_pkg::StFull;
            end else begin
              tbl_valid[k] = 1'b1;
              tbl_chan[k] = r.num;
              tbl_fam[k] = r.fam;
              tbl_hi[k] = hi;
              tbl_lo[k] = lo;
              tbl_port[k] = r.port;
              tbl_expiry[k] = expiry_after(r.now);
              live_bindings = live_bindings + 1;
              res.created = 1'b1;
              hit = k;
            end
          end
        end
      end
      cbt_pkg::OpFindNum: begin
        hit = lookup_channel(r.num, r.now);
        if (hit < 0) res.status = cbt_pkg::StNotFound;
      end
      cbt_pkg::OpFindPeer: begin
        hit = lookup_peer(r.fam, hi, lo, r.port, r.now);
        if (hit < 0) res.status = cbt_pkg::StNotFound;
      end
      default: res.status = cbt_pkg::StBadAttr;
    endcase
    if (hit >= 0) begin
      res.channel = tbl_chan[hit];
      res.family = tbl_fam[hit];
      res.addr_hi = tbl_hi[hit];
      res.addr_lo = tbl_lo[hit];
      res.port = tbl_port[hit];
    end
    res.count = live_bindings;
    return res;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  // Check each popped result against the oldest expectation
  always @(posedge clk_i) begin
    cbt_pkg::res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", {61'd0, status_o}, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) report("status", status_o, want.status);
        if (created_o !== want.created) report("created", created_o, want.created);
        if (found_channel_o !== want.channel) report("channel", found_channel_o, want.channel);
        if (found_family_o !== want.family) report("family", found_family_o, want.family);
        if (found_addr_hi_o !== want.addr_hi) report("addr_hi", found_addr_hi_o, want.addr_hi);
        if (found_addr_lo_o !== want.addr_lo) report("addr_lo", found_addr_lo_o, want.addr_lo);
        if (found_port_o !== want.port) report("port", found_port_o, want.port);
        if (bound_count_o !== want.count) report("count", bound_count_o, want.count);
      end
    end
  end

  // Drive pop: random idling, a long hold-off, and a quiet stretch
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold) pop <= 1'b0;
      else if (quiet_window) pop <= 1'b1;
      else pop <= ($urandom_range(99) >= 21);
    end
  end

  initial begin
    wait (cycles == 3000);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == cbt_pkg::RegRelayFamily) relay_fam = data[0];
    else if (idx == cbt_pkg::RegLifetime) lifetime = data;
  endtask

  // Offer one request, hold it until accepted, then record its expectation
  task automatic send(chan_req_t r);
    cbt_pkg::res_t pred;
    int gap;
    gap = 0;
    if (!quiet_window && $urandom_range(99) < 21) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= r.op;
    has_channel_number_i <= r.has_num;
    channel_number_i <= r.num;
    has_peer_i <= r.has_peer;
    peer_family_i <= r.fam;
    peer_addr_hi_i <= r.hi;
    peer_addr_lo_i <= r.lo;
    peer_port_i <= r.port;
    now_seconds_i <= r.now;
    do @(posedge clk_i); while (full);
    pred = apply_request(r);
    if (r.fixed) begin
      pred = '0;
      pred.status = r.fixed_status;
      pred.count = r.fixed_count;
    end
    pending_results.push_back(pred);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic chan_req_t row(logic [1:0] op, logic hn, logic [15:0] num, logic hp,
                                    logic fam, logic [63:0] hi, logic [63:0] lo,
                                    logic [15:0] port, logic [31:0] now, bit fixed,
                                    logic [2:0] st, logic [4:0] cnt);
    chan_req_t r;
    r.op = op; r.has_num = hn; r.num = num; r.has_peer = hp; r.fam = fam;
    r.hi = hi; r.lo = lo; r.port = port; r.now = now;
    r.fixed = fixed; r.fixed_status = st; r.fixed_count = cnt;
    return r;
  endfunction

  // Mostly well-formed requests on a small pool of channels and peers, some noise
  function automatic chan_req_t random_request();
    chan_req_t r;
    int k;
    int p;
    int pick;
    clock_now = clock_now + $urandom_range(0, lifetime / 8 + 1);
    r.fixed = 1'b0;
    r.fixed_status = '0;
    r.fixed_count = '0;
    if ($urandom_range(99) < 15) begin
      r.op = $urandom_range(3);
      r.has_num = $urandom_range(1);
      r.num = $urandom;
      r.has_peer = $urandom_range(1);
      r.fam = $urandom_range(1);
      r.hi = {$urandom, $urandom};
      r.lo = {$urandom, $urandom};
      r.port = $urandom;
      r.now = ($urandom_range(1)) ? clock_now : $urandom;
      return r;
    end
    k = $urandom_range(PoolSize - 1);
    p = ($urandom_range(99) < 70) ? k : $urandom_range(PoolSize - 1);
    pick = $urandom_range(99);
    r.op = (pick < 50) ? cbt_pkg::OpBind : (pick < 75) ? cbt_pkg::OpFindNum : cbt_pkg::OpFindPeer;
    r.has_num = ($urandom_range(99) < 97);
    r.has_peer = ($urandom_range(99) < 97);
    r.num = pool_chan[k];
    r.fam = ($urandom_range(99) < 92) ? relay_fam : ~relay_fam;
    r.hi = pool_hi[p];
    r.lo = pool_lo[p];
    r.port = pool_port[p];
    r.now = clock_now;
    return r;
  endfunction

  initial begin
    chan_req_t plan [$];
    logic [15:0] phase_life [5];
    logic        phase_fam [5];
    logic [31:0] phase_start [5];
    phase_life = '{16'd600, 16'd1, 16'd65535, 16'd40, 16'd5};
    phase_fam = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_start = '{32'd0, 32'd1000, 32'hffff_0000, 32'd5000, 32'd77};
    for (int i = 0; i < Slots; i++) tbl_valid[i] = 1'b0;
    live_bindings = '0;
    relay_fam = 1'b0;
    lifetime = cbt_pkg::LifetimeReset;
    for (int i = 0; i < PoolSize; i++) begin
      pool_chan[i] = $urandom_range(cbt_pkg::ChanMin, cbt_pkg::ChanMax);
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
      pool_port[i] = $urandom;
    end
    pool_chan[0] = cbt_pkg::ChanMin;
    pool_chan[1] = cbt_pkg::ChanMax;
    pool_port[1] = 16'hffff;
    pool_port[2] = 16'h0000;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(cbt_pkg::RegRelayFamily, 16'd0);
    write_reg(cbt_pkg::RegLifetime, 16'd600);

    // Directed rows: empty lookups, attribute and family errors, create, refresh, conflict, expiry
    plan.push_back(row(cbt_pkg::OpFindNum, 1, 16'h4000, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StNotFound, 0));
    plan.push_back(row(cbt_pkg::OpFindPeer, 1, 16'h4000, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StNotFound, 0));
    plan.push_back(row(cbt_pkg::OpBind, 0, 16'h4000, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StBadAttr, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h4000, 0, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StBadAttr, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h3fff, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StBadAttr, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h8000, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StBadAttr, 0));
    plan.push_back(row(OpUnused, 1, 16'h4000, 1, 0, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StBadAttr, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h4000, 1, 1, 0, 64'd1, 16'd443, 32'd0,
                       1, cbt_pkg::StFamily, 0));
    // IPv4 peer with junk in the ignored upper bits
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h4000, 1, 0, 64'hffff_ffff_ffff_ffff,
                       64'hdead_beef_0a00_0001, 16'd443, 32'd100, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h7fff, 1, 0, 0, 64'hffff_ffff_ffff_ffff,
                       16'hffff, 32'd100, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h4000, 1, 0, 0, 64'h0a00_0001, 16'd443,
                       32'd400, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h4000, 1, 0, 0, 64'hffff_ffff, 16'hffff,
                       32'd500, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpFindNum, 0, 16'h7fff, 0, 1, 0, 0, 0, 32'd500, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpFindPeer, 0, 16'h0, 0, 0, 64'h5, 64'h0a00_0001, 16'd443,
                       32'd500, 0, 0, 0));
    plan.push_back(row(cbt_pkg::OpFindNum, 1, 16'h4000, 1, 0, 0, 0, 0, 32'hffff_ffff,
                       0, 0, 0));
    plan.push_back(row(cbt_pkg::OpBind, 1, 16'h5000, 1, 0, 0, 64'h0, 16'd0, 32'hffff_ffff,
                       0, 0, 0));
    plan.push_back(row(cbt_pkg::OpFindPeer, 1, 16'h0, 1, 0, 0, 64'h0, 16'd0, 32'hffff_fff0,
                       0, 0, 0));
    plan.push_back(row(cbt_pkg::OpFindNum, 1, 16'h5000, 1, 0, 0, 0, 0, 32'hffff_ffff,
                       0, 0, 0));
    foreach (plan[i]) send(plan[i]);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(cbt_pkg::RegRelayFamily, {15'd0, phase_fam[ph]});
      write_reg(cbt_pkg::RegLifetime, phase_life[ph]);
      clock_now = phase_start[ph];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        quiet_window = (ph == 2 && n >= 60 && n < 260);
        send(random_request());
      end
      quiet_window = 1'b0;
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS channel_binding_table_unit");
    end else begin
      $display("FAIL channel_binding_table_unit");
    end
    $finish;
  end

endmodule
